/* rtl/hce_pkg.sv */
// shared types, constants and helpers for the histogram contrast equalizer
package hce_pkg;

  localparam int unsigned LEVELS      = 32;
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned BIN_W       = 17;
  localparam int unsigned CUM_W       = BIN_W + LEVEL_W;
  localparam int unsigned GREY_W      = 8;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd127;
  localparam logic [BIN_W-1:0]  GAIN_ONE   = 17'd127;
  localparam logic [BIN_W-1:0]  BIN_MAX    = 17'h1FFFF;
  localparam logic [GREY_W-1:0] GREY_MAX   = 8'hFF;

  localparam int unsigned FRAME_PIXELS_DEF = 239 * 320;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACC   = 2'd1,
    OP_MAP   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  // grey into rgb565: red and blue carry the top five bits, green twice that
  function automatic logic [PIX_W-1:0] pack_grey(input logic [GREY_W-1:0] grey);
    logic [4:0] rb;
    rb = grey[7:3];
    return {rb, rb, 1'b0, rb};
  endfunction

endpackage

/* rtl/hce_div.sv */
// table scaling pipeline: count times gain over unity, then full scale over frame size
module hce_div
  import hce_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CUM_W-1:0]  cum,
  input  logic [GAIN_W-1:0] gain,
  output logic              done,
  output logic [GREY_W-1:0] grey
);

  localparam int unsigned PROD_W   = CUM_W + GAIN_W;
  // gain over unity stays below 2.01, so two bits above the count width
  localparam int unsigned SCALED_W = CUM_W + 2;
  // unity is below 2^7, so this shift keeps the reciprocal exact for every product
  localparam int unsigned GAIN_SHIFT = PROD_W + 7;
  localparam int unsigned RECIP_W    = PROD_W + 1;
  localparam longint unsigned GAIN_ONE_L   = 64'(GAIN_ONE);
  localparam longint unsigned GAIN_RECIP_L =
    ((64'd1 << GAIN_SHIFT) + GAIN_ONE_L - 1) / GAIN_ONE_L;
  localparam logic [RECIP_W-1:0] GainRecip = RECIP_W'(GAIN_RECIP_L);

  localparam int unsigned FRAME_MOD     = FRAME_PIXELS % (1 << BIN_W);
  localparam int unsigned FRAME_DIV_INT = (FRAME_MOD == 0) ? 1 : FRAME_MOD;
  // scaled count is below the frame size here, so twice its bit count is exact
  localparam int unsigned FRAME_SHIFT   = 2 * $clog2(FRAME_DIV_INT);
  localparam int unsigned FRAME_RECIP_W = BIN_W + GREY_W + 1;
  localparam int unsigned FPROD_W       = BIN_W + FRAME_RECIP_W;
  localparam longint unsigned FRAME_DIV_L   = 64'(FRAME_DIV_INT);
  localparam longint unsigned FRAME_RECIP_L =
    (64'(GREY_MAX) * (64'd1 << FRAME_SHIFT) + FRAME_DIV_L - 1) / FRAME_DIV_L;
  localparam logic [BIN_W-1:0]         FrameDiv   = BIN_W'(FRAME_DIV_INT);
  localparam logic [FRAME_RECIP_W-1:0] FrameRecip = FRAME_RECIP_W'(FRAME_RECIP_L);

  logic                      stage1;
  logic                      stage2;
  logic [PROD_W-1:0]         prod;
  logic [SCALED_W-1:0]       scaled;
  logic [PROD_W+RECIP_W-1:0] gain_prod;
  logic [FPROD_W-1:0]        frame_prod;
  logic                      clamp;

  assign gain_prod  = {{RECIP_W{1'b0}}, prod} * {{PROD_W{1'b0}}, GainRecip};
  // a scaled count at or above the frame size maps to full scale
  assign clamp      = {{(SCALED_W-BIN_W){1'b0}}, FrameDiv} <= scaled;
  assign frame_prod = {{FRAME_RECIP_W{1'b0}}, scaled[BIN_W-1:0]} *
                      {{BIN_W{1'b0}}, FrameRecip};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{GAIN_W{1'b0}}, cum} * {{CUM_W{1'b0}}, gain};
    end
    if (stage1) begin
      scaled <= gain_prod[GAIN_SHIFT +: SCALED_W];
    end
    if (stage2) begin
      grey <= clamp ? GREY_MAX : GREY_W'(frame_prod >> FRAME_SHIFT);
    end
  end

endmodule

/* rtl/hce_front.sv */
// input side: takes items, drops no-ops and queues commands for the back end
module hce_front
  import hce_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             in_cmd;
  logic             push;
  logic             pop;

  assign in_cmd.op    = op_t'(in_op);
  assign in_cmd.level = in_pixel[LEVEL_W-1:0];

  assign in_ready  = count != CNT_W'(QUEUE_DEPTH);
  assign push      = in_valid && in_ready && (in_cmd.op != OP_NOP);
  assign cmd_valid = count != '0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* rtl/hce_back.sv */
// back end: histogram bins, table build sequencer and output register
module hce_back
  import hce_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  input  logic              gain_valid,
  input  logic [GAIN_W-1:0] gain_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pixel
);

  typedef enum logic [3:0] {
    ST_RUN = 4'b0001,
    ST_SUM = 4'b0010,
    ST_MUL = 4'b0100,
    ST_DIV = 4'b1000
  } state_t;

  state_t             state;
  logic [BIN_W-1:0]   bin_counts [LEVELS];
  logic [GREY_W-1:0]  map_table [LEVELS];
  logic               table_ready;
  logic [GAIN_W-1:0]  gain;
  logic [LEVEL_W-1:0] idx;
  logic [CUM_W-1:0]   cum;

  logic               div_start;
  logic               div_done;
  logic [GREY_W-1:0]  div_grey;
  logic               out_free;
  logic               map_go;

  hce_div #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .cum   (cum),
    .gain  (gain),
    .done  (div_done),
    .grey  (div_grey)
  );

  assign div_start = (state == ST_MUL);

  assign out_free = !out_valid || out_ready;
  assign map_go   = (state == ST_RUN) && cmd_valid && (cmd.op == OP_MAP) &&
                    table_ready && out_free;

  always_comb begin
    cmd_ready = 1'b0;
    if (state == ST_RUN && cmd_valid) begin
      unique case (cmd.op)
        OP_CLEAR, OP_ACC: cmd_ready = 1'b1;
        OP_MAP:           cmd_ready = table_ready && out_free;
        default:          cmd_ready = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      table_ready <= 1'b0;
      gain        <= GAIN_RESET;
      out_valid   <= 1'b0;
      idx         <= '0;
      cum         <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        bin_counts[i] <= '0;
      end
    end else begin
      if (gain_valid) begin
        gain <= gain_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (map_go) begin
        out_valid <= 1'b1;
      end

      unique case (state)
        ST_RUN: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_CLEAR: begin
                for (int i = 0; i < LEVELS; i++) begin
                  bin_counts[i] <= '0;
                end
                table_ready <= 1'b0;
              end
              OP_ACC: begin
                if (bin_counts[cmd.level] != BIN_MAX) begin
                  bin_counts[cmd.level] <= bin_counts[cmd.level] + 1'b1;
                end
                table_ready <= 1'b0;
              end
              OP_MAP: begin
                // the map item stays queued until the table is rebuilt
                if (!table_ready) begin
                  idx   <= '0;
                  cum   <= '0;
                  state <= ST_SUM;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SUM: begin
          cum   <= cum + {{(CUM_W-BIN_W){1'b0}}, bin_counts[idx]};
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (idx == LEVEL_W'(LEVELS - 1)) begin
              table_ready <= 1'b1;
              state       <= ST_RUN;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_SUM;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      map_table[idx] <= div_grey;
    end
    if (map_go) begin
      out_pixel <= pack_grey(map_table[cmd.level]);
    end
  end

endmodule

/* rtl/histogram_contrast_equalizer.sv */
// Histogram contrast equalizer over rgb565 grey pixels (grey level = low five
// bits). Each input transfer carries a command in tuser: clear the 32-bin
// histogram, count a pixel into it, or map a pixel through the equalization
// table; only map commands give an output transfer. Commands pass through a
// four-entry queue to the back end, which handles clear, count and map at one
// per cycle while it is not rebuilding the table and the output register can
// take a result. The first map after the histogram changes first rebuilds the
// table: each of the 32 levels takes a cumulative add, then a three-stage
// scaling pipeline (multiply by gain, reciprocal multiply for the division by
// 127, reciprocal multiply for the division by the frame size with clamping);
// the map result issues once every level is written. Gain writes are to be
// made while no commands are in flight.
module histogram_contrast_equalizer
  import hce_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // pixel_in[15:0]
  input  logic [1:0]        s_axis_tuser,   // operation[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // pixel_out[15:0]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GAIN_W-1:0] cfg_data        // gain[7:0]
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  hce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_pixel  (s_axis_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  hce_back #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .gain_valid (cfg_valid),
    .gain_data  (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pixel  (m_axis_tdata)
  );

endmodule
